/* sv/mtrs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtrs_pkg
// Types, constants and the column-forming function of the tile serializer.
// ----------------------------------------------------------------------------
package mtrs_pkg;

  localparam int unsigned MAX_CHIPS = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_H      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT  = 2'd3;

  localparam logic [3:0] CHIP_COUNT_RESET = 4'd4;
  localparam logic [3:0] NOOP_ADDR        = 4'h0;
  localparam logic [7:0] NOOP_VALUE       = 8'h00;

  typedef enum logic [1:0] {
    ORIENT_TRANSPOSE = 2'd0,
    ORIENT_DIRECT    = 2'd1,
    ORIENT_MIRROR    = 2'd2,
    ORIENT_REVERSE   = 2'd3
  } orient_t;

  typedef logic [7:0][7:0] tile_t;

  function automatic logic [7:0] bit_rev8(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[3'(7 - i)] = v[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] col_byte(tile_t rows, logic [2:0] col, orient_t orient,
                                          logic flip, logic inv);
    logic [7:0] t;
    logic [7:0] b;
    t = '0;
    case (orient)
      ORIENT_TRANSPOSE: begin
        for (int r = 0; r < 8; r++) begin
          t[3'(7 - r)] = rows[r][col];
        end
        b = flip ? bit_rev8(t) : t;
      end
      ORIENT_DIRECT: begin
        b = rows[col];
      end
      ORIENT_MIRROR: begin
        for (int r = 0; r < 8; r++) begin
          t[r] = rows[r][~col];
        end
        b = flip ? bit_rev8(t) : t;
      end
      default: begin
        b = bit_rev8(rows[~col]);
      end
    endcase
    return inv ? ~b : b;
  endfunction

endpackage : mtrs_pkg
`default_nettype wire

/* sv/matrix_tile_rotate_serializer_unit.sv */
`default_nettype none
// An accepted tile is registered into the work registers, and each of its words
// then into the out_* registers. Throughput: one word per cycle unless out_stall
// holds the output; a tile is 8 * max(target_chip + 1, min(chip_count, 8)) words.
// The next tile is taken in the cycle its predecessor's last word goes out.
// Reset: synchronous, active low; clears handshake state and restores the
// configuration registers (orientation 0, no flip, no invert, four chips).
// ----------------------------------------------------------------------------
// matrix_tile_rotate_serializer_unit
// Forms eight column bytes of an 8x8 tile and streams them as register words
// framed for a daisy chain of matrix driver chips.
// ----------------------------------------------------------------------------
module matrix_tile_rotate_serializer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mtrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mtrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [2:0]                      in_target_chip,
  input  wire logic [7:0]                      in_row_0,
  input  wire logic [7:0]                      in_row_1,
  input  wire logic [7:0]                      in_row_2,
  input  wire logic [7:0]                      in_row_3,
  input  wire logic [7:0]                      in_row_4,
  input  wire logic [7:0]                      in_row_5,
  input  wire logic [7:0]                      in_row_6,
  input  wire logic [7:0]                      in_row_7,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [3:0]                      out_reg_address,
  output      logic [7:0]                      out_reg_value,
  output      logic                            out_frame_end,
  output      logic                            out_last
);
  import mtrs_pkg::*;

  orient_t    orient_r;
  logic       flip_r;
  logic       inv_r;
  logic [3:0] chip_count_r;

  logic       work_valid_r;
  tile_t      cols_r;
  logic [2:0] target_r;
  logic [2:0] frame_last_r;
  logic [2:0] col_r;
  logic [2:0] pos_r;

  logic       out_valid_r;
  logic [3:0] out_addr_r;
  logic [7:0] out_value_r;
  logic       out_fend_r;
  logic       out_last_r;

  tile_t      rows;
  tile_t      cols_nxt;
  logic [3:0] count;
  logic [2:0] frame_last_nxt;
  logic       emit;
  logic       accept;
  logic       word_fend;
  logic       word_last;
  logic       word_data;

  assign rows = {in_row_7, in_row_6, in_row_5, in_row_4,
                 in_row_3, in_row_2, in_row_1, in_row_0};

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      cols_nxt[c] = col_byte(rows, 3'(c), orient_r, flip_r, inv_r);
    end
  end

  assign count = (chip_count_r > 4'(MAX_CHIPS)) ? 4'(MAX_CHIPS) : chip_count_r;
  assign frame_last_nxt = (count > ({1'b0, in_target_chip} + 4'd1)) ?
                          3'(count - 4'd1) : in_target_chip;

  assign emit      = work_valid_r && (!out_valid_r || !out_stall);
  assign word_data = (pos_r == target_r);
  assign word_fend = (pos_r == frame_last_r);
  assign word_last = word_fend && (col_r == 3'd7);
  assign in_stall  = work_valid_r && !(emit && word_last);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r     <= ORIENT_TRANSPOSE;
      flip_r       <= 1'b0;
      inv_r        <= 1'b0;
      chip_count_r <= CHIP_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIENTATION: orient_r     <= orient_t'(cfg_data[1:0]);
        CFG_FLIP_H:      flip_r       <= cfg_data[0];
        CFG_INVERT:      inv_r        <= cfg_data[0];
        CFG_CHIP_COUNT:  chip_count_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
    end else if (accept) begin
      work_valid_r <= 1'b1;
    end else if (emit && word_last) begin
      work_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cols_r       <= cols_nxt;
      target_r     <= in_target_chip;
      frame_last_r <= frame_last_nxt;
      col_r        <= 3'd0;
      pos_r        <= 3'd0;
    end else if (emit) begin
      if (word_fend) begin
        pos_r <= 3'd0;
        col_r <= col_r + 3'd1;
      end else begin
        pos_r <= pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= work_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr_r  <= word_data ? ({1'b0, col_r} + 4'd1) : NOOP_ADDR;
      out_value_r <= word_data ? cols_r[col_r] : NOOP_VALUE;
      out_fend_r  <= word_fend;
      out_last_r  <= word_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_address = out_addr_r;
  assign out_reg_value   = out_value_r;
  assign out_frame_end   = out_fend_r;
  assign out_last        = out_last_r;

endmodule : matrix_tile_rotate_serializer_unit
`default_nettype wire

/* sv/mtrs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtrs_checker
// Port-level checks of the tile serializer's result stream.
// ----------------------------------------------------------------------------
module mtrs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] out_reg_address,
  input wire logic [7:0] out_reg_value,
  input wire logic       out_frame_end,
  input wire logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reg_address) &&
      $stable(out_reg_value) && $stable(out_frame_end) && $stable(out_last))
    else $error("stalled word changed");

  a_noop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reg_address == 4'd0) |-> (out_reg_value == 8'd0))
    else $error("no-op word carries data");

  a_last_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_frame_end && (out_reg_address == 4'd8 ||
      out_reg_address == 4'd0))
    else $error("last word not at end of final frame");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reg_address <= 4'd8))
    else $error("register address out of range");

endmodule : mtrs_checker

bind matrix_tile_rotate_serializer_unit mtrs_checker u_mtrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_reg_address (out_reg_address),
  .out_reg_value   (out_reg_value),
  .out_frame_end   (out_frame_end),
  .out_last        (out_last)
);
`default_nettype wire

/* test/matrix_tile_word_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_tile_word_checker
// Watches the config port and both channels of the tile serializer. It keeps
// its own copy of the settings, expands each accepted tile into the register
// words of its eight chip-select frames, and compares every output word
// against the oldest one still waiting.
// ----------------------------------------------------------------------------
module matrix_tile_word_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mtrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [2:0]                      in_target_chip,
  input  logic [7:0]                      in_row_0,
  input  logic [7:0]                      in_row_1,
  input  logic [7:0]                      in_row_2,
  input  logic [7:0]                      in_row_3,
  input  logic [7:0]                      in_row_4,
  input  logic [7:0]                      in_row_5,
  input  logic [7:0]                      in_row_6,
  input  logic [7:0]                      in_row_7,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [3:0]                      out_reg_address,
  input  logic [7:0]                      out_reg_value,
  input  logic                            out_frame_end,
  input  logic                            out_last,
  output int unsigned                     mismatches,
  output int unsigned                     words_pending,
  output int unsigned                     tiles_taken,
  output int unsigned                     words_checked
);
  import mtrs_pkg::*;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] value;
    logic       frame_end;
    logic       last;
  } chain_word_t;

  orient_t     orient;
  logic        flip_on;
  logic        invert_on;
  logic [3:0]  chain_len;
  chain_word_t chain_words[$];

  function automatic logic [7:0] reverse_bits(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic logic [7:0] column_of(input logic [7:0][7:0] rows, input int c);
    logic [7:0] b;
    b = '0;
    case (orient)
      ORIENT_TRANSPOSE: begin
        for (int r = 0; r < 8; r++) b[7-r] = rows[r][c];
        if (flip_on) b = reverse_bits(b);
      end
      ORIENT_DIRECT: begin
        b = rows[c];
      end
      ORIENT_MIRROR: begin
        for (int r = 0; r < 8; r++) b[r] = rows[r][7-c];
        if (flip_on) b = reverse_bits(b);
      end
      default: begin
        b = reverse_bits(rows[7-c]);
      end
    endcase
    return invert_on ? ~b : b;
  endfunction

  task automatic append_word(input chain_word_t w);
    chain_words.insert(chain_words.size(), w);
  endtask

  task automatic queue_tile(input logic [2:0] target, input logic [7:0][7:0] rows);
    int unsigned active;
    int unsigned trailing;
    active   = (chain_len > MAX_CHIPS) ? MAX_CHIPS : chain_len;
    trailing = (active > target + 1) ? active - target - 1 : 0;
    for (int c = 0; c < 8; c++) begin
      for (int i = 0; i < target; i++) begin
        append_word(chain_word_t'{NOOP_ADDR, NOOP_VALUE, 1'b0, 1'b0});
      end
      append_word(chain_word_t'{4'(c + 1), column_of(rows, c), trailing == 0,
                                c == 7 && trailing == 0});
      for (int i = 0; i < trailing; i++) begin
        append_word(chain_word_t'{NOOP_ADDR, NOOP_VALUE, i + 1 == trailing,
                                  c == 7 && i + 1 == trailing});
      end
    end
  endtask

  always @(posedge clk) begin
    chain_word_t got;
    chain_word_t want;
    if (!rst_n) begin
      orient    = ORIENT_TRANSPOSE;
      flip_on   = 1'b0;
      invert_on = 1'b0;
      chain_len = CHIP_COUNT_RESET;
      chain_words.delete();
    end else begin
      // outputs first: a word leaving now never belongs to a tile taken now
      if (out_valid && !out_stall) begin
        got = chain_word_t'{out_reg_address, out_reg_value, out_frame_end, out_last};
        if (chain_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected word addr %0d value %02h frame_end %0b last %0b",
                     $realtime, got.addr, got.value, got.frame_end, got.last);
          end
        end else begin
          want = chain_words.pop_front();
          words_checked++;
          if (got.addr !== want.addr || got.value !== want.value ||
              got.frame_end !== want.frame_end || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word mismatch: expected addr %0d value %02h frame_end %0b last %0b",
                       $realtime, want.addr, want.value, want.frame_end, want.last);
              $display("%0t:                 actual addr %0d value %02h frame_end %0b last %0b",
                       $realtime, got.addr, got.value, got.frame_end, got.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        queue_tile(in_target_chip, {in_row_7, in_row_6, in_row_5, in_row_4,
                                    in_row_3, in_row_2, in_row_1, in_row_0});
        tiles_taken++;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIENTATION: orient    = orient_t'(cfg_data[1:0]);
          CFG_FLIP_H:      flip_on   = cfg_data[0];
          CFG_INVERT:      invert_on = cfg_data[0];
          CFG_CHIP_COUNT:  chain_len = cfg_data[3:0];
          default: ;
        endcase
      end
    end
    words_pending = chain_words.size();
  end

endmodule

/* test/matrix_tile_rotate_serializer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_tile_rotate_serializer_unit_test
// Drives tiles into the serializer under directed and random settings of
// orientation, flip, invert and chain length, with random gaps on the input
// and random stalls on the output; the word checker does the comparison.
// ----------------------------------------------------------------------------
module matrix_tile_rotate_serializer_unit_test;
  import mtrs_pkg::*;

  localparam logic [7:0][7:0] ASYM_TILE = 64'hC755_330F_1824_4281;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            in_target_chip;
  logic [7:0]            in_row_0, in_row_1, in_row_2, in_row_3;
  logic [7:0]            in_row_4, in_row_5, in_row_6, in_row_7;
  logic                  out_valid;
  logic                  out_stall;
  logic [3:0]            out_reg_address;
  logic [7:0]            out_reg_value;
  logic                  out_frame_end;
  logic                  out_last;

  int unsigned mismatches;
  int unsigned words_pending;
  int unsigned tiles_taken;
  int unsigned words_checked;
  int unsigned settings_used;
  bit          steady_feed;

  always #4 clk = ~clk;

  matrix_tile_rotate_serializer_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_target_chip  (in_target_chip),
    .in_row_0        (in_row_0),
    .in_row_1        (in_row_1),
    .in_row_2        (in_row_2),
    .in_row_3        (in_row_3),
    .in_row_4        (in_row_4),
    .in_row_5        (in_row_5),
    .in_row_6        (in_row_6),
    .in_row_7        (in_row_7),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_address (out_reg_address),
    .out_reg_value   (out_reg_value),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

  matrix_tile_word_checker word_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_target_chip  (in_target_chip),
    .in_row_0        (in_row_0),
    .in_row_1        (in_row_1),
    .in_row_2        (in_row_2),
    .in_row_3        (in_row_3),
    .in_row_4        (in_row_4),
    .in_row_5        (in_row_5),
    .in_row_6        (in_row_6),
    .in_row_7        (in_row_7),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_address (out_reg_address),
    .out_reg_value   (out_reg_value),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .words_pending   (words_pending),
    .tiles_taken     (tiles_taken),
    .words_checked   (words_checked)
  );

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // only called with the input idle and every word out
  task automatic set_config(input logic [3:0] orient_val, input logic [3:0] flip_val,
                            input logic [3:0] invert_val, input logic [3:0] chips_val);
    repeat (2) @(negedge clk);
    write_reg(CFG_ORIENTATION, orient_val);
    write_reg(CFG_FLIP_H, flip_val);
    write_reg(CFG_INVERT, invert_val);
    write_reg(CFG_CHIP_COUNT, chips_val);
    settings_used++;
  endtask

  task automatic send_tile(input logic [2:0] target, input logic [7:0][7:0] rows);
    int unsigned gap;
    gap = steady_feed ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_target_chip <= target;
    in_row_0 <= rows[0];
    in_row_1 <= rows[1];
    in_row_2 <= rows[2];
    in_row_3 <= rows[3];
    in_row_4 <= rows[4];
    in_row_5 <= rows[5];
    in_row_6 <= rows[6];
    in_row_7 <= rows[7];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_row();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_chip_count();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2: return 4'd8;
      3: return 4'd1;
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  // output side: random stall per word, with stretches of none
  initial begin : word_sink
    int unsigned hold;
    int unsigned words_left;
    bit          free_run;
    words_left = 0;
    free_run   = 1'b0;
    out_stall  = 1'b0;
    @(posedge rst_n);
    forever begin
      if (words_left == 0) begin
        free_run   = ($urandom_range(0, 3) == 0);
        words_left = $urandom_range(20, 80);
      end
      words_left--;
      hold = free_run ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    logic [7:0][7:0] rows;
    int unsigned     random_sent;
    int unsigned     burst;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_target_chip = '0;
    {in_row_7, in_row_6, in_row_5, in_row_4} = '0;
    {in_row_3, in_row_2, in_row_1, in_row_0} = '0;
    settings_used  = 1;
    steady_feed    = 1'b0;
    random_sent    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: four chips, target inside, on the last chip and beyond
    send_tile(3'd0, '0);
    send_tile(3'd3, '1);
    send_tile(3'd7, ASYM_TILE);
    send_tile(3'd2, ~ASYM_TILE);
    drain_words();

    for (int o = 0; o < 4; o++) begin
      for (int f = 0; f < 2; f++) begin
        set_config(4'(o), 4'(f), 4'((o ^ f) & 1), 4'd4);
        send_tile(3'(o * 2 + f), ASYM_TILE);
        drain_words();
      end
    end

    set_config(4'd0, 4'd0, 4'd0, 4'd8);
    send_tile(3'd7, ASYM_TILE);
    send_tile(3'd0, 64'h0123_4567_89AB_CDEF);
    drain_words();
    set_config(4'd1, 4'd1, 4'd1, 4'd1);
    send_tile(3'd0, ASYM_TILE);
    send_tile(3'd5, ASYM_TILE);
    drain_words();
    // zero chips
    set_config(4'd2, 4'd1, 4'd0, 4'd0);
    send_tile(3'd0, ASYM_TILE);
    send_tile(3'd4, ASYM_TILE);
    drain_words();
    // values wider than the fields, chip count above the maximum
    set_config(4'hE, 4'hF, 4'h3, 4'hF);
    send_tile(3'd7, ASYM_TILE);
    send_tile(3'd2, ASYM_TILE);
    drain_words();

    while (random_sent < 260) begin
      set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), pick_chip_count());
      steady_feed = ($urandom_range(0, 2) == 0);
      burst = $urandom_range(8, 30);
      for (int n = 0; n < burst; n++) begin
        for (int r = 0; r < 8; r++) rows[r] = pick_row();
        send_tile(3'($urandom_range(0, 7)), rows);
        random_sent++;
        if (n == 5 || $urandom_range(0, 31) == 0) drain_words();
      end
      drain_words();
    end

    repeat (20) @(negedge clk);
    $display("Covered %0d tiles and %0d register words under %0d settings of",
             tiles_taken, words_checked, settings_used);
    $display("orientation, flip, invert and chain length, with input gaps and output stalls");
    if (mismatches == 0) begin
      $display("matrix_tile_rotate_serializer_unit_test: PASS");
    end else begin
      $display("matrix_tile_rotate_serializer_unit_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("matrix_tile_rotate_serializer_unit_test: FAIL");
    $finish;
  end

endmodule

/* matrix_tile_rotate_serializer_unit.f */
sv/mtrs_pkg.sv
sv/matrix_tile_rotate_serializer_unit.sv
sv/mtrs_checker.sv
test/matrix_tile_word_checker.sv
test/matrix_tile_rotate_serializer_unit_test.sv
